// ===== design/ror_pkg.sv =====
// shared types and constants of the rectangle outline rasteriser
`timescale 1ns / 1ps
`default_nettype none

package ror_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_DRAW  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// stream widths
	localparam int MODE_W     = 2;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 96;

	// signed working width for row and column arithmetic
	localparam int COORD_W = 14;

	// field widths
	localparam int POS_W   = 12;
	localparam int EXT_W   = 11;
	localparam int ROWSEL_W = 7;
	localparam int CNT_W   = 16;
	localparam int USED_W  = 8;
	localparam int WORD_W  = 64;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture input request
		logic clr;       // empty canvas and counters
		logic init;      // update counters, build column masks
		logic sweep;     // read-modify-write pass over rows
		logic rd;        // read one row for a slice
		logic res_load;  // capture result into output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              sweep_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/ror_ctrl.sv =====
// controller state machine of the rectangle outline rasteriser
`timescale 1ns / 1ps
`default_nettype none

module ror_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire           m_tready,
	input  ror_pkg::sts_t sts,
	output ror_pkg::cmd_t cmd
);
	import ror_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_CLEAR  = 3'd2;
	localparam logic [2:0] S_INIT   = 3'd3;
	localparam logic [2:0] S_SWEEP  = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_vld_q;
	logic       slot_free;

	assign slot_free = !out_vld_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_vld_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.mode)
					MODE_CLEAR: state_d = S_CLEAR;
					MODE_DRAW:  state_d = S_INIT;
					MODE_READ:  state_d = S_READ;
					default:    state_d = S_DONE;
				endcase
			end
			S_CLEAR: begin
				cmd.clr = 1'b1;
				state_d = S_DONE;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.res_load = slot_free;
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_vld_q || m_tready))
		else $error("result loaded over a waiting result");

	// at most one datapath command at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.clr, cmd.init, cmd.sweep, cmd.rd, cmd.res_load}))
		else $error("conflicting datapath commands");

	// a new request is not taken right after one was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");

	// a result follows a finished sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep && sts.sweep_done) |=> (state_q == S_DONE))
		else $error("sweep finished without result stage");

endmodule

`default_nettype wire

// ===== design/ror_dp.sv =====
// datapath of the rectangle outline rasteriser: canvas memory, counters, result
`timescale 1ns / 1ps
`default_nettype none

module ror_dp #(
	parameter int CANVAS_SIZE = 128
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [ror_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire  [ror_pkg::MODE_W-1:0]       s_tuser,
	input  ror_pkg::cmd_t                    cmd,
	output ror_pkg::sts_t                    sts,
	output logic [ror_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import ror_pkg::*;

	localparam int IDX_W  = $clog2(CANVAS_SIZE);
	localparam int RCNT_W = $clog2(CANVAS_SIZE + 1);
	localparam int RSEL_W = (IDX_W > ROWSEL_W ? IDX_W : ROWSEL_W) + 1;
	localparam int PAD_W  = (CANVAS_SIZE > 2 * WORD_W) ? CANVAS_SIZE : 2 * WORD_W;
	localparam logic signed [COORD_W-1:0] SIZE_S = COORD_W'(CANVAS_SIZE);
	localparam logic [RCNT_W-1:0] SIZE_C = RCNT_W'(CANVAS_SIZE);

	// captured request
	logic [MODE_W-1:0]         mode_q;
	logic signed [POS_W-1:0]   x_q;
	logic signed [POS_W-1:0]   y_q;
	logic [EXT_W-1:0]          w_q;
	logic [EXT_W-1:0]          h_q;
	logic [ROWSEL_W-1:0]       row_q;
	logic                      ws_q;

	// state
	logic [CNT_W-1:0]          count_q;
	logic [USED_W-1:0]         used_q;
	logic                      inside_q;
	logic [CANVAS_SIZE-1:0]    row_vld_q;

	// draw geometry
	logic signed [COORD_W-1:0] xs, ys, xe, ye, xl, yl, used_s, rs, cs;
	logic signed [COORD_W-1:0] xs_q, xe_q, xl_q;
	logic [CANVAS_SIZE-1:0]    pm_d, rm_d, pm_q, rm_q;
	logic                      inside_d;

	// sweep pipeline
	logic [RCNT_W-1:0]         rd_cnt_q;
	logic                      wr_vld_s1;
	logic [IDX_W-1:0]          wr_row_s1;
	logic                      row_in, on_edge;
	logic [CANVAS_SIZE-1:0]    row_mask, wr_data;

	// memory port
	logic [CANVAS_SIZE-1:0]    mem [CANVAS_SIZE];
	logic                      mem_re;
	logic [IDX_W-1:0]          rd_addr;
	logic [CANVAS_SIZE-1:0]    rd_data_s1;
	logic                      rd_vld_s1;
	logic                      rd_ok_s1;
	logic [RSEL_W-1:0]         row_ext;
	logic                      row_ok;
	logic [PAD_W-1:0]          row_pad;
	logic [WORD_W-1:0]         slice;

	assign sts.mode       = mode_q;
	assign sts.sweep_done = (rd_cnt_q == SIZE_C) && !wr_vld_s1;

	// geometry of the captured rectangle
	always_comb begin
		xs = COORD_W'(x_q);
		ys = COORD_W'(y_q);
		xe = xs + COORD_W'(w_q);
		ye = ys + COORD_W'(h_q);
		xl = xe - COORD_W'(1);
		yl = ye - COORD_W'(1);
		used_s = COORD_W'(used_q);
		inside_d = (xs >= 0) && (ys >= 0) && (xe < SIZE_S) && (ye < SIZE_S);
	end

	// column masks: end points of row runs and the clipped column run
	always_comb begin
		pm_d = '0;
		rm_d = '0;
		cs   = '0;
		for (int c = 0; c < CANVAS_SIZE; c++) begin
			cs = COORD_W'(c);
			pm_d[c] = (cs == ys) || (cs == yl);
			rm_d[c] = (cs >= ys) && (cs < ye);
		end
	end

	// pixels set in the row being written back
	always_comb begin
		rs       = COORD_W'(wr_row_s1);
		row_in   = (rs >= xs_q) && (rs < xe_q);
		on_edge  = (rs == xs_q) || (rs == xl_q);
		row_mask = ({CANVAS_SIZE{row_in}} & pm_q) | ({CANVAS_SIZE{on_edge}} & rm_q);
		wr_data  = (rd_vld_s1 ? rd_data_s1 : '0) | row_mask;
	end

	// read address selection
	always_comb begin
		row_ext = RSEL_W'(row_q);
		row_ok  = (row_ext < RSEL_W'(CANVAS_SIZE));
		mem_re  = cmd.rd || (cmd.sweep && (rd_cnt_q < SIZE_C));
		rd_addr = cmd.rd ? row_ext[IDX_W-1:0] : rd_cnt_q[IDX_W-1:0];
	end

	// slice of the read row, columns past the canvas read as zero
	always_comb begin
		row_pad = PAD_W'(rd_vld_s1 ? rd_data_s1 : '0);
		slice   = row_pad[{ws_q, 6'd0} +: WORD_W];
	end

	// canvas memory
	always_ff @(posedge clk) begin
		if (wr_vld_s1) begin
			mem[wr_row_s1] <= wr_data;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// request capture, masks and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= s_tuser;
			x_q    <= s_tdata[11:0];
			y_q    <= s_tdata[23:12];
			w_q    <= s_tdata[34:24];
			h_q    <= s_tdata[45:35];
			row_q  <= s_tdata[52:46];
			ws_q   <= s_tdata[53];
		end
		if (cmd.init) begin
			pm_q     <= pm_d;
			rm_q     <= rm_d;
			xs_q     <= xs;
			xe_q     <= xe;
			xl_q     <= xl;
			inside_q <= inside_d;
		end
		if (cmd.sweep && (rd_cnt_q < SIZE_C)) begin
			wr_row_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (cmd.rd) begin
			rd_ok_s1 <= row_ok;
		end
		if (mem_re) begin
			rd_vld_s1 <= row_vld_q[rd_addr];
		end
		if (cmd.res_load) begin
			m_tdata <= {7'd0, used_q, count_q,
				(mode_q == MODE_DRAW) && inside_q,
				((mode_q == MODE_READ) && rd_ok_s1) ? slice : {WORD_W{1'b0}}};
		end
	end

	// counters, row valid bits and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			used_q    <= '0;
			row_vld_q <= '0;
			rd_cnt_q  <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr) begin
				count_q   <= '0;
				used_q    <= '0;
				row_vld_q <= '0;
			end
			if (cmd.init) begin
				if (inside_d && (count_q != {CNT_W{1'b1}})) begin
					count_q <= count_q + CNT_W'(1);
				end
				if ((xe < SIZE_S) && (xe > used_s)) begin
					used_q <= xe[USED_W-1:0];
				end
				rd_cnt_q  <= '0;
				wr_vld_s1 <= 1'b0;
			end
			if (cmd.sweep) begin
				if (rd_cnt_q < SIZE_C) begin
					rd_cnt_q  <= rd_cnt_q + RCNT_W'(1);
					wr_vld_s1 <= 1'b1;
				end else begin
					wr_vld_s1 <= 1'b0;
				end
			end
			if (wr_vld_s1) begin
				row_vld_q[wr_row_s1] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/rect_outline_raster_top.sv =====
// top level of the rectangle outline rasteriser
//
// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  tuser: mode; tdata: x, y, width, height, row, word
// m_*      out        m_tvalid/m_tready  tdata: pixel_word, fully_inside, count, rows_used
//
// one request at a time; a clear or read passes through decode, its clear or read state and
// the done state, where the result is loaded into the output register
// a draw passes through decode, init, sweep and done: a read-modify-write pass over
// every canvas row through the one-read one-write canvas memory, one row per cycle, then
// the last row's write-back drains before the result is loaded
// reset empties the canvas at once through per-row valid bits and zeroes the counters
// a finished result waits in the output register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none

module rect_outline_raster_top #(
	parameter int CANVAS_SIZE = 128
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// [11:0] x_pos, [23:12] y_pos, [34:24] rect_width, [45:35] rect_height,
	// [52:46] row_select, [53] word_select, [55:54] zero
	input  wire  [ror_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] mode
	input  wire  [ror_pkg::MODE_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// [63:0] pixel_word, [64] fully_inside, [80:65] inside_count,
	// [88:81] rows_used, [95:89] zero
	output logic [ror_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import ror_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	ror_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// canvas and counters
	ror_dp #(
		.CANVAS_SIZE (CANVAS_SIZE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking stream testbench for the rectangle outline rasteriser
`timescale 1ns / 1ps

module tb;
	import ror_pkg::*;

	localparam int CANVAS = 128;
	localparam int RANDOM_ITEMS = 1600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRESSURE_HOLD = 400;
	localparam int DRAIN_CYCLES = 150;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         mode;
		logic signed [11:0] x_pos;
		logic signed [11:0] y_pos;
		logic [10:0]        rect_width;
		logic [10:0]        rect_height;
		logic [6:0]         row_select;
		logic               word_select;
	} raster_req_t;

	typedef struct {
		logic [63:0] pixel_word;
		logic        fully_inside;
		logic [15:0] inside_count;
		logic [7:0]  rows_used;
	} raster_res_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [MODE_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predicted canvas and counters
	logic [CANVAS-1:0] canvas_bits [CANVAS];
	logic [15:0]       inside_total;
	logic [7:0]        row_extent;
	raster_res_t       pending_results[$];

	// run control shared between the stimulus and the result sink
	bit source_calm = 1'b0;
	bit sink_calm = 1'b0;
	bit pressure_req = 1'b0;
	bit pressure_ack = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;

	int errors = 0;
	int n_checked = 0;
	int n_draws = 0;
	int n_reads = 0;
	int n_clears = 0;
	int n_fully_in = 0;

	rect_outline_raster_top #(
		.CANVAS_SIZE(CANVAS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_model();
		foreach (canvas_bits[r]) canvas_bits[r] = '0;
		inside_total = '0;
		row_extent = '0;
	endfunction

	function automatic void set_pixel(int r, int c);
		if (r >= 0 && r < CANVAS && c >= 0 && c < CANVAS)
			canvas_bits[r][c] = 1'b1;
	endfunction

	// applies one request to the predicted state and returns its result
	function automatic raster_res_t rasterise(raster_req_t req);
		raster_res_t res;
		int x, y, w, h, xe, ye, j;
		res.pixel_word = '0;
		res.fully_inside = 1'b0;
		x = int'(req.x_pos);
		y = int'(req.y_pos);
		w = int'(req.rect_width);
		h = int'(req.rect_height);
		xe = x + w;
		ye = y + h;
		case (req.mode)
			MODE_CLEAR: begin
				clear_model();
			end
			MODE_DRAW: begin
				if (x >= 0 && y >= 0 && xe < CANVAS && ye < CANVAS) begin
					res.fully_inside = 1'b1;
					if (inside_total != 16'hFFFF)
						inside_total = inside_total + 16'd1;
				end
				if (xe < CANVAS && xe > int'(row_extent))
					row_extent = xe[7:0];
				// horizontal runs, clipped to the canvas rows
				for (j = (x < 0) ? 0 : x; j < xe && j < CANVAS; j++) begin
					set_pixel(j, y);
					set_pixel(j, ye - 1);
				end
				// vertical runs, clipped to the canvas columns
				for (j = (y < 0) ? 0 : y; j < ye && j < CANVAS; j++) begin
					set_pixel(x, j);
					set_pixel(xe - 1, j);
				end
			end
			MODE_READ: begin
				res.pixel_word = canvas_bits[req.row_select][64*req.word_select +: 64];
			end
			default: ;
		endcase
		res.inside_count = inside_total;
		res.rows_used = row_extent;
		return res;
	endfunction

	function automatic raster_req_t make_request(logic [1:0] mode, int x, int y, int w, int h,
			int row, int word);
		raster_req_t req;
		req.mode = mode;
		req.x_pos = 12'(x);
		req.y_pos = 12'(y);
		req.rect_width = 11'(w);
		req.rect_height = 11'(h);
		req.row_select = 7'(row);
		req.word_select = 1'(word);
		return req;
	endfunction

	// random request, mostly draws near the canvas and row reads, some clears and noise
	function automatic raster_req_t rand_request();
		raster_req_t req;
		int pick;
		req.x_pos = 12'($urandom);
		req.y_pos = 12'($urandom);
		req.rect_width = 11'($urandom);
		req.rect_height = 11'($urandom);
		req.row_select = 7'($urandom);
		req.word_select = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			req.mode = MODE_CLEAR;
		end else if (pick < 5) begin
			req.mode = MODE_UNUSED;
		end else if (pick < 50) begin
			req.mode = MODE_DRAW;
			if ($urandom_range(0, 9) < 8) begin
				req.x_pos = 12'(int'($urandom_range(0, 159)) - 16);
				req.y_pos = 12'(int'($urandom_range(0, 159)) - 16);
				req.rect_width = 11'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 140) :
					$urandom_range(0, 40));
				req.rect_height = 11'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 140) :
					$urandom_range(0, 40));
			end
		end else begin
			req.mode = MODE_READ;
		end
		return req;
	endfunction

	// offers one request after an optional gap and predicts it once accepted
	task automatic send_request(raster_req_t req);
		int gap;
		int pick;
		gap = 0;
		if (!source_calm) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				gap = $urandom_range(1, 3);
			else if (pick < 36)
				gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req.mode;
		s_tdata <= {2'b00, req.word_select, req.row_select, req.rect_height, req.rect_width,
			req.y_pos, req.x_pos};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(rasterise(req));
		case (req.mode)
			MODE_CLEAR: n_clears++;
			MODE_DRAW: n_draws++;
			MODE_READ: n_reads++;
			default: ;
		endcase
		if (pending_results[$].fully_inside)
			n_fully_in++;
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// result sink: compares each result and drives m_tready with random stalls
	always @(posedge clk) begin : result_sink
		raster_res_t want;
		int pick;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: 0x%0h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("pixel_word", want.pixel_word, m_tdata[63:0]);
				check_field("fully_inside", 64'(want.fully_inside), 64'(m_tdata[64]));
				check_field("inside_count", 64'(want.inside_count), 64'(m_tdata[80:65]));
				check_field("rows_used", 64'(want.rows_used), 64'(m_tdata[88:81]));
				n_checked++;
			end
		end
		if (pressure_req != pressure_ack) begin
			pressure_ack = pressure_req;
			stall_left = PRESSURE_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (sink_calm) begin
			m_tready <= 1'b1;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				m_tready <= 1'b0;
				stall_left = (pick < 13) ? $urandom_range(0, 3) : $urandom_range(10, 60);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_empty_read();
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 0, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 127, 1));
	endtask

	// largest rectangle that still lies wholly on the canvas
	task automatic test_full_outline();
		send_request(make_request(MODE_DRAW, 0, 0, 127, 127, 0, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 0, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 0, 1));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 126, 1));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 64, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 127, 1));
	endtask

	// zero width and zero height still leave runs one step back
	task automatic test_zero_extent();
		send_request(make_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
		send_request(make_request(MODE_DRAW, 10, 20, 0, 5, 0, 0));
		send_request(make_request(MODE_DRAW, 30, 40, 6, 0, 0, 0));
		send_request(make_request(MODE_DRAW, 50, 60, 0, 0, 0, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 9, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 10, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 30, 0));
	endtask

	// off-canvas extremes, partial clipping and the rows-used bound
	task automatic test_clipping();
		send_request(make_request(MODE_DRAW, -2048, -2048, 2047, 2047, 0, 0));
		send_request(make_request(MODE_DRAW, 2047, 2047, 2047, 2047, 0, 0));
		send_request(make_request(MODE_DRAW, -5, -5, 20, 200, 0, 0));
		send_request(make_request(MODE_DRAW, 100, 60, 27, 8, 0, 0));
		send_request(make_request(MODE_DRAW, 120, 0, 8, 4, 0, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 100, 0));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 100, 1));
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_unused_mode();
		send_request(make_request(MODE_UNUSED, 5, 5, 10, 10, 100, 1));
		send_request(make_request(MODE_READ, -1, -1, 2047, 2047, 120, 0));
	endtask

	// sink holds off long enough for the block to fill while requests keep coming
	task automatic test_backpressure();
		source_calm = 1'b1;
		sink_calm = 1'b0;
		pressure_req = ~pressure_req;
		repeat (12) send_request(rand_request());
		source_calm = 1'b0;
	endtask

	task automatic test_random_mix();
		raster_req_t req;
		int sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// switch idling on and off in stretches
			if (sent % 100 == 0) begin
				source_calm = ($urandom_range(0, 3) == 0);
				sink_calm = ($urandom_range(0, 3) == 0);
			end
			req = rand_request();
			send_request(req);
			if (req.mode != MODE_UNUSED)
				sent++;
		end
		source_calm = 1'b0;
		sink_calm = 1'b0;
	endtask

	initial begin
		clear_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_read();
		test_full_outline();
		test_zero_extent();
		test_clipping();
		test_unused_mode();
		test_backpressure();
		test_random_mix();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d draws (%0d wholly on canvas), %0d row reads and %0d clears",
			n_draws, n_fully_in, n_reads, n_clears);
		$display("%0d results checked under random gaps, stalls and one long hold-off",
			n_checked);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
